[src/tbd_pkg.sv]
// shared widths, constants and request/result types for the three-body derivative unit
`default_nettype none
package tbd_pkg;

    localparam int FIELD_W        = 32;
    localparam int FRAC_W         = 24;
    localparam int MQ_W           = FRAC_W + 1;
    localparam int DX_W           = FIELD_W + 2;
    localparam int MAG_W          = FIELD_W;
    localparam int SQ_W           = 2 * MAG_W;
    localparam int ROOT_W         = SQ_W / 2;
    localparam int S_W            = SQ_W - FRAC_W;
    localparam int NUM_W          = MAG_W + FRAC_W;
    localparam int D_W            = S_W + ROOT_W - FRAC_W;
    localparam int TERM_W         = 64;
    localparam int ACC_W          = TERM_W + 2;
    localparam int WORD_WIDTH_DEF = 32;

    localparam logic [FIELD_W-1:0] MASS_RESET = 32'd52731336;
    localparam logic [FIELD_W:0]   MASS_ROUND = 33'd128;

    typedef struct packed {
        logic signed [FIELD_W-1:0] pos_x;
        logic signed [FIELD_W-1:0] vel_x;
        logic signed [FIELD_W-1:0] pos_y;
        logic signed [FIELD_W-1:0] vel_y;
    } t_req;

    typedef struct packed {
        logic signed [FIELD_W-1:0] d_pos_x;
        logic signed [FIELD_W-1:0] d_vel_x;
        logic signed [FIELD_W-1:0] d_pos_y;
        logic signed [FIELD_W-1:0] d_vel_y;
        logic                      overflow;
    } t_rsp;

endpackage
`default_nettype wire

[src/tbd_sqrt.sv]
// pipelined integer square root, one result bit per stage
`default_nettype none
module tbd_sqrt import tbd_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic [SQ_W-1:0]   i_val,
    output logic      [ROOT_W-1:0] o_root
);
    localparam int REM_W = ROOT_W + 3;

    logic [REM_W-1:0]  r_rem  [ROOT_W];
    logic [ROOT_W-1:0] r_root [ROOT_W];
    logic [SQ_W-1:0]   r_val  [ROOT_W];

    for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
        logic [REM_W-1:0]  rem_in;
        logic [ROOT_W-1:0] root_in;
        logic [SQ_W-1:0]   val_in;
        logic [REM_W-1:0]  cand;
        logic [REM_W-1:0]  trial;
        logic              ge;

        if (k == 0) begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign val_in  = i_val;
        end else begin : g_next
            assign rem_in  = r_rem[k-1];
            assign root_in = r_root[k-1];
            assign val_in  = r_val[k-1];
        end

        // bring down the next two radicand bits, try (4*root + 1)
        assign cand  = {rem_in[REM_W-3:0], val_in[SQ_W-1 -: 2]};
        assign trial = {1'b0, root_in, 2'b01};
        assign ge    = cand >= trial;

        always_ff @(posedge i_clk) begin
            r_rem[k]  <= ge ? cand - trial : cand;
            r_root[k] <= {root_in[ROOT_W-2:0], ge};
            r_val[k]  <= {val_in[SQ_W-3:0], 2'b00};
        end
    end

    assign o_root = r_root[ROOT_W-1];

endmodule
`default_nettype wire

[src/tbd_div.sv]
// pipelined restoring divider, one quotient bit per stage
`default_nettype none
module tbd_div import tbd_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic [NUM_W-1:0] i_num,
    input  wire logic [D_W-1:0]   i_den,
    output logic      [NUM_W-1:0] o_quo
);
    logic [D_W-1:0]   r_rem [NUM_W];
    logic [D_W-1:0]   r_den [NUM_W];
    logic [NUM_W-1:0] r_num [NUM_W];
    logic [NUM_W-1:0] r_quo [NUM_W];

    for (genvar k = 0; k < NUM_W; k++) begin : g_stage
        logic [D_W-1:0]   rem_in;
        logic [D_W-1:0]   den_in;
        logic [NUM_W-1:0] num_in;
        logic [NUM_W-1:0] quo_in;
        logic [D_W:0]     cand;
        logic [D_W:0]     diff;
        logic             ge;

        if (k == 0) begin : g_first
            assign rem_in = '0;
            assign den_in = i_den;
            assign num_in = i_num;
            assign quo_in = '0;
        end else begin : g_next
            assign rem_in = r_rem[k-1];
            assign den_in = r_den[k-1];
            assign num_in = r_num[k-1];
            assign quo_in = r_quo[k-1];
        end

        assign cand = {rem_in, num_in[NUM_W-1]};
        assign ge   = cand >= {1'b0, den_in};
        assign diff = cand - {1'b0, den_in};

        always_ff @(posedge i_clk) begin
            r_rem[k] <= ge ? diff[D_W-1:0] : cand[D_W-1:0];
            r_den[k] <= den_in;
            r_num[k] <= {num_in[NUM_W-2:0], 1'b0};
            r_quo[k] <= {quo_in[NUM_W-2:0], ge};
        end
    end

    assign o_quo = r_quo[NUM_W-1];

endmodule
`default_nettype wire

[src/three_body_derivative_unit.sv]
// an accepted request passes stages 1 to 5, the square roots, stages 6 and 7, the dividers and stages 8 to 10 in order
// throughput: one request per cycle; busy stays low, a request may follow every cycle
// the depth is set by the 32-stage square root and the 56-stage quotient pipelines
// reset: synchronous active-low; clears all valid bits and restores the mass ratio
// results are strobed for one cycle and cannot be held off
`default_nettype none
module three_body_derivative_unit import tbd_pkg::*; #(
    parameter int WORD_WIDTH = WORD_WIDTH_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire t_req               i_req,
    output logic                    o_strobe,
    output t_rsp                    o_rsp,
    input  wire logic               i_cfg_wr_en,
    input  wire logic [FIELD_W-1:0] i_cfg_wr_data
);
    localparam int LAT = 5 + ROOT_W + 2 + NUM_W + 3;
    localparam int PROD_W = MQ_W + MAG_W;
    localparam int HI_W = S_W + ROOT_W - FRAC_W;
    localparam int LO_W = S_W + FRAC_W;
    localparam logic signed [ACC_W-1:0] SAT_HI =
        {{(ACC_W-WORD_WIDTH+1){1'b0}}, {(WORD_WIDTH-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] SAT_LO = ~SAT_HI;
    localparam logic [TERM_W-1:0] TERM_HUGE = TERM_W'(1) << (TERM_W - 2);

    typedef struct packed {
        logic signed [DX_W-1:0]    base_x;
        logic signed [DX_W-1:0]    base_y;
        logic signed [FIELD_W-1:0] vx;
        logic signed [FIELD_W-1:0] vy;
        logic                      neg_x1;
        logic                      neg_x2;
        logic                      neg_y;
        logic [NUM_W-1:0]          n1x;
        logic [NUM_W-1:0]          n1y;
        logic [NUM_W-1:0]          n2x;
        logic [NUM_W-1:0]          n2y;
        logic [S_W-1:0]            s1;
        logic [S_W-1:0]            s2;
        logic                      dz1;
        logic                      dz2;
        logic                      nz1x;
        logic                      nz1y;
        logic                      nz2x;
        logic                      nz2y;
    } t_side;

    logic [FIELD_W-1:0] r_mass;
    logic               accept;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mass <= MASS_RESET;
        end else if (i_cfg_wr_en) begin
            r_mass <= i_cfg_wr_data;
        end
    end

    // stage 1: capture request, mass in Q.24 rounded half up
    logic               r_p1_vld;
    t_req               r_p1_req;
    logic [MQ_W-1:0]    r_p1_mqb;
    logic [MQ_W-1:0]    r_p1_mqs;
    logic [FIELD_W:0]   mass_rnd;
    logic [MQ_W-1:0]    mqb;

    assign mass_rnd = {1'b0, r_mass} + MASS_ROUND;
    assign mqb      = mass_rnd[FIELD_W -: MQ_W];

    always_ff @(posedge i_clk) begin
        r_p1_req <= i_req;
        r_p1_mqb <= mqb;
        r_p1_mqs <= (MQ_W'(1) << FRAC_W) - mqb;
    end

    // stage 2: offsets to the two bodies
    logic                   r_p2_vld;
    t_req                   r_p2_req;
    logic signed [DX_W-1:0] r_p2_dx1;
    logic signed [DX_W-1:0] r_p2_dx2;
    logic [MQ_W-1:0]        r_p2_mqb;
    logic [MQ_W-1:0]        r_p2_mqs;

    always_ff @(posedge i_clk) begin
        r_p2_req <= r_p1_req;
        r_p2_mqb <= r_p1_mqb;
        r_p2_mqs <= r_p1_mqs;
        r_p2_dx1 <= DX_W'(r_p1_req.pos_x) + DX_W'(r_p1_mqb);
        r_p2_dx2 <= DX_W'(r_p1_req.pos_x) - DX_W'(r_p1_mqs);
    end

    // stage 3: magnitudes and signs, linear parts of the accelerations
    logic                      r_p3_vld;
    logic [MAG_W-1:0]          r_p3_ux1;
    logic [MAG_W-1:0]          r_p3_ux2;
    logic [MAG_W-1:0]          r_p3_uy;
    logic                      r_p3_neg_x1;
    logic                      r_p3_neg_x2;
    logic                      r_p3_neg_y;
    logic signed [DX_W-1:0]    r_p3_base_x;
    logic signed [DX_W-1:0]    r_p3_base_y;
    logic signed [FIELD_W-1:0] r_p3_vx;
    logic signed [FIELD_W-1:0] r_p3_vy;
    logic [MQ_W-1:0]           r_p3_mqb;
    logic [MQ_W-1:0]           r_p3_mqs;
    logic signed [DX_W-1:0]    abs_x1;
    logic signed [DX_W-1:0]    abs_x2;
    logic signed [DX_W-1:0]    abs_y;
    logic signed [DX_W-1:0]    y_ext;

    assign y_ext  = DX_W'(r_p2_req.pos_y);
    assign abs_x1 = r_p2_dx1[DX_W-1] ? -r_p2_dx1 : r_p2_dx1;
    assign abs_x2 = r_p2_dx2[DX_W-1] ? -r_p2_dx2 : r_p2_dx2;
    assign abs_y  = y_ext[DX_W-1] ? -y_ext : y_ext;

    always_ff @(posedge i_clk) begin
        r_p3_ux1    <= abs_x1[MAG_W-1:0];
        r_p3_ux2    <= abs_x2[MAG_W-1:0];
        r_p3_uy     <= abs_y[MAG_W-1:0];
        r_p3_neg_x1 <= r_p2_dx1[DX_W-1];
        r_p3_neg_x2 <= r_p2_dx2[DX_W-1];
        r_p3_neg_y  <= y_ext[DX_W-1];
        r_p3_base_x <= DX_W'(r_p2_req.pos_x) + (DX_W'(r_p2_req.vel_y) <<< 1);
        r_p3_base_y <= DX_W'(r_p2_req.pos_y) - (DX_W'(r_p2_req.vel_x) <<< 1);
        r_p3_vx     <= r_p2_req.vel_x;
        r_p3_vy     <= r_p2_req.vel_y;
        r_p3_mqb    <= r_p2_mqb;
        r_p3_mqs    <= r_p2_mqs;
    end

    // stage 4: squares and gravity numerators
    logic             r_p4_vld;
    logic [SQ_W-1:0]  r_p4_sq_x1;
    logic [SQ_W-1:0]  r_p4_sq_x2;
    logic [SQ_W-1:0]  r_p4_sq_y;
    t_side            r_p4_side;
    t_side            n_p4_side;
    logic [PROD_W-1:0] prod_1x;
    logic [PROD_W-1:0] prod_1y;
    logic [PROD_W-1:0] prod_2x;
    logic [PROD_W-1:0] prod_2y;

    assign prod_1x = PROD_W'(r_p3_mqs) * PROD_W'(r_p3_ux1);
    assign prod_1y = PROD_W'(r_p3_mqs) * PROD_W'(r_p3_uy);
    assign prod_2x = PROD_W'(r_p3_mqb) * PROD_W'(r_p3_ux2);
    assign prod_2y = PROD_W'(r_p3_mqb) * PROD_W'(r_p3_uy);

    always_comb begin
        n_p4_side        = '0;
        n_p4_side.base_x = r_p3_base_x;
        n_p4_side.base_y = r_p3_base_y;
        n_p4_side.vx     = r_p3_vx;
        n_p4_side.vy     = r_p3_vy;
        n_p4_side.neg_x1 = r_p3_neg_x1;
        n_p4_side.neg_x2 = r_p3_neg_x2;
        n_p4_side.neg_y  = r_p3_neg_y;
        n_p4_side.n1x    = prod_1x[NUM_W-1:0];
        n_p4_side.n1y    = prod_1y[NUM_W-1:0];
        n_p4_side.n2x    = prod_2x[NUM_W-1:0];
        n_p4_side.n2y    = prod_2y[NUM_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        r_p4_sq_x1 <= SQ_W'(r_p3_ux1) * SQ_W'(r_p3_ux1);
        r_p4_sq_x2 <= SQ_W'(r_p3_ux2) * SQ_W'(r_p3_ux2);
        r_p4_sq_y  <= SQ_W'(r_p3_uy) * SQ_W'(r_p3_uy);
        r_p4_side  <= n_p4_side;
    end

    // stage 5: squared distances
    logic            r_p5_vld;
    logic [SQ_W-1:0] r_p5_r2_1;
    logic [SQ_W-1:0] r_p5_r2_2;
    t_side           r_p5_side;
    t_side           n_p5_side;
    logic [SQ_W-1:0] r2_1;
    logic [SQ_W-1:0] r2_2;

    assign r2_1 = r_p4_sq_x1 + r_p4_sq_y;
    assign r2_2 = r_p4_sq_x2 + r_p4_sq_y;

    always_comb begin
        n_p5_side    = r_p4_side;
        n_p5_side.s1 = r2_1[SQ_W-1:FRAC_W];
        n_p5_side.s2 = r2_2[SQ_W-1:FRAC_W];
    end

    always_ff @(posedge i_clk) begin
        r_p5_r2_1 <= r2_1;
        r_p5_r2_2 <= r2_2;
        r_p5_side <= n_p5_side;
    end

    logic [ROOT_W-1:0] root1;
    logic [ROOT_W-1:0] root2;

    tbd_sqrt u_sqrt1 (
        .i_clk  (i_clk),
        .i_val  (r_p5_r2_1),
        .o_root (root1)
    );

    tbd_sqrt u_sqrt2 (
        .i_clk  (i_clk),
        .i_val  (r_p5_r2_2),
        .o_root (root2)
    );

    logic  r_sq_vld  [ROOT_W];
    t_side r_sq_side [ROOT_W];

    always_ff @(posedge i_clk) begin
        r_sq_side[0] <= r_p5_side;
        for (int k = 1; k < ROOT_W; k++) begin
            r_sq_side[k] <= r_sq_side[k-1];
        end
    end

    // stage 6: cube partial products s*r split at the binary point
    logic             r_p6_vld;
    logic [HI_W-1:0]  r_p6_hi1;
    logic [LO_W-1:0]  r_p6_lo1;
    logic [HI_W-1:0]  r_p6_hi2;
    logic [LO_W-1:0]  r_p6_lo2;
    t_side            r_p6_side;
    t_side            sq_out;

    assign sq_out = r_sq_side[ROOT_W-1];

    always_ff @(posedge i_clk) begin
        r_p6_hi1  <= HI_W'(sq_out.s1) * HI_W'(root1[ROOT_W-1:FRAC_W]);
        r_p6_lo1  <= LO_W'(sq_out.s1) * LO_W'(root1[FRAC_W-1:0]);
        r_p6_hi2  <= HI_W'(sq_out.s2) * HI_W'(root2[ROOT_W-1:FRAC_W]);
        r_p6_lo2  <= LO_W'(sq_out.s2) * LO_W'(root2[FRAC_W-1:0]);
        r_p6_side <= sq_out;
    end

    // stage 7: cubed distances
    logic           r_p7_vld;
    logic [D_W-1:0] r_p7_d1;
    logic [D_W-1:0] r_p7_d2;
    t_side          r_p7_side;
    t_side          dv_in;

    always_ff @(posedge i_clk) begin
        r_p7_d1   <= D_W'(r_p6_hi1) + D_W'(r_p6_lo1[LO_W-1:FRAC_W]);
        r_p7_d2   <= D_W'(r_p6_hi2) + D_W'(r_p6_lo2[LO_W-1:FRAC_W]);
        r_p7_side <= r_p6_side;
    end

    always_comb begin
        dv_in      = r_p7_side;
        dv_in.dz1  = r_p7_d1 == '0;
        dv_in.dz2  = r_p7_d2 == '0;
        dv_in.nz1x = r_p7_side.n1x != '0;
        dv_in.nz1y = r_p7_side.n1y != '0;
        dv_in.nz2x = r_p7_side.n2x != '0;
        dv_in.nz2y = r_p7_side.n2y != '0;
    end

    logic [NUM_W-1:0] quo_1x;
    logic [NUM_W-1:0] quo_1y;
    logic [NUM_W-1:0] quo_2x;
    logic [NUM_W-1:0] quo_2y;

    tbd_div u_div_1x (.i_clk(i_clk), .i_num(r_p7_side.n1x), .i_den(r_p7_d1), .o_quo(quo_1x));
    tbd_div u_div_1y (.i_clk(i_clk), .i_num(r_p7_side.n1y), .i_den(r_p7_d1), .o_quo(quo_1y));
    tbd_div u_div_2x (.i_clk(i_clk), .i_num(r_p7_side.n2x), .i_den(r_p7_d2), .o_quo(quo_2x));
    tbd_div u_div_2y (.i_clk(i_clk), .i_num(r_p7_side.n2y), .i_den(r_p7_d2), .o_quo(quo_2y));

    logic  r_dv_vld  [NUM_W];
    t_side r_dv_side [NUM_W];

    always_ff @(posedge i_clk) begin
        r_dv_side[0] <= dv_in;
        for (int k = 1; k < NUM_W; k++) begin
            r_dv_side[k] <= r_dv_side[k-1];
        end
    end

    // stage 8: signed gravity terms, zero distance forces a huge term unless the numerator is zero
    logic                      r_p8_vld;
    logic signed [TERM_W-1:0]  r_p8_t1x;
    logic signed [TERM_W-1:0]  r_p8_t2x;
    logic signed [TERM_W-1:0]  r_p8_t1y;
    logic signed [TERM_W-1:0]  r_p8_t2y;
    logic signed [DX_W-1:0]    r_p8_base_x;
    logic signed [DX_W-1:0]    r_p8_base_y;
    logic signed [FIELD_W-1:0] r_p8_vx;
    logic signed [FIELD_W-1:0] r_p8_vy;
    logic                      r_p8_dz;
    t_side                     dv_out;
    logic [TERM_W-1:0]         q1x;
    logic [TERM_W-1:0]         q1y;
    logic [TERM_W-1:0]         q2x;
    logic [TERM_W-1:0]         q2y;

    assign dv_out = r_dv_side[NUM_W-1];

    always_comb begin
        q1x = dv_out.dz1 ? (dv_out.nz1x ? TERM_HUGE : '0) : TERM_W'(quo_1x);
        q1y = dv_out.dz1 ? (dv_out.nz1y ? TERM_HUGE : '0) : TERM_W'(quo_1y);
        q2x = dv_out.dz2 ? (dv_out.nz2x ? TERM_HUGE : '0) : TERM_W'(quo_2x);
        q2y = dv_out.dz2 ? (dv_out.nz2y ? TERM_HUGE : '0) : TERM_W'(quo_2y);
    end

    always_ff @(posedge i_clk) begin
        r_p8_t1x    <= dv_out.neg_x1 ? -signed'(q1x) : signed'(q1x);
        r_p8_t1y    <= dv_out.neg_y  ? -signed'(q1y) : signed'(q1y);
        r_p8_t2x    <= dv_out.neg_x2 ? -signed'(q2x) : signed'(q2x);
        r_p8_t2y    <= dv_out.neg_y  ? -signed'(q2y) : signed'(q2y);
        r_p8_base_x <= dv_out.base_x;
        r_p8_base_y <= dv_out.base_y;
        r_p8_vx     <= dv_out.vx;
        r_p8_vy     <= dv_out.vy;
        r_p8_dz     <= dv_out.dz1 || dv_out.dz2;
    end

    // stage 9: exact acceleration sums
    logic                      r_p9_vld;
    logic signed [ACC_W-1:0]   r_p9_ax;
    logic signed [ACC_W-1:0]   r_p9_ay;
    logic signed [FIELD_W-1:0] r_p9_vx;
    logic signed [FIELD_W-1:0] r_p9_vy;
    logic                      r_p9_dz;

    always_ff @(posedge i_clk) begin
        r_p9_ax <= ACC_W'(r_p8_base_x) - ACC_W'(r_p8_t1x) - ACC_W'(r_p8_t2x);
        r_p9_ay <= ACC_W'(r_p8_base_y) - ACC_W'(r_p8_t1y) - ACC_W'(r_p8_t2y);
        r_p9_vx <= r_p8_vx;
        r_p9_vy <= r_p8_vy;
        r_p9_dz <= r_p8_dz;
    end

    // stage 10: saturation to the word range
    logic                    r_out_vld;
    t_rsp                    r_out;
    logic signed [ACC_W-1:0] ext_vx;
    logic signed [ACC_W-1:0] ext_vy;
    logic signed [ACC_W-1:0] sat_vx;
    logic signed [ACC_W-1:0] sat_ax;
    logic signed [ACC_W-1:0] sat_vy;
    logic signed [ACC_W-1:0] sat_ay;
    logic                    hit;

    function automatic logic signed [ACC_W-1:0] f_clip(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] res;
        res = v;
        if (v > SAT_HI) begin
            res = SAT_HI;
        end else if (v < SAT_LO) begin
            res = SAT_LO;
        end
        return res;
    endfunction

    always_comb begin
        ext_vx = ACC_W'(r_p9_vx);
        ext_vy = ACC_W'(r_p9_vy);
        sat_vx = f_clip(ext_vx);
        sat_ax = f_clip(r_p9_ax);
        sat_vy = f_clip(ext_vy);
        sat_ay = f_clip(r_p9_ay);
        hit    = (sat_vx != ext_vx) || (sat_ax != r_p9_ax) ||
                 (sat_vy != ext_vy) || (sat_ay != r_p9_ay) || r_p9_dz;
    end

    always_ff @(posedge i_clk) begin
        r_out.d_pos_x  <= sat_vx[FIELD_W-1:0];
        r_out.d_vel_x  <= sat_ax[FIELD_W-1:0];
        r_out.d_pos_y  <= sat_vy[FIELD_W-1:0];
        r_out.d_vel_y  <= sat_ay[FIELD_W-1:0];
        r_out.overflow <= hit;
    end

    // valid bits travel alongside the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_vld  <= 1'b0;
            r_p2_vld  <= 1'b0;
            r_p3_vld  <= 1'b0;
            r_p4_vld  <= 1'b0;
            r_p5_vld  <= 1'b0;
            r_p6_vld  <= 1'b0;
            r_p7_vld  <= 1'b0;
            r_p8_vld  <= 1'b0;
            r_p9_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            for (int k = 0; k < ROOT_W; k++) begin
                r_sq_vld[k] <= 1'b0;
            end
            for (int k = 0; k < NUM_W; k++) begin
                r_dv_vld[k] <= 1'b0;
            end
        end else begin
            r_p1_vld    <= accept;
            r_p2_vld    <= r_p1_vld;
            r_p3_vld    <= r_p2_vld;
            r_p4_vld    <= r_p3_vld;
            r_p5_vld    <= r_p4_vld;
            r_sq_vld[0] <= r_p5_vld;
            for (int k = 1; k < ROOT_W; k++) begin
                r_sq_vld[k] <= r_sq_vld[k-1];
            end
            r_p6_vld    <= r_sq_vld[ROOT_W-1];
            r_p7_vld    <= r_p6_vld;
            r_dv_vld[0] <= r_p7_vld;
            for (int k = 1; k < NUM_W; k++) begin
                r_dv_vld[k] <= r_dv_vld[k-1];
            end
            r_p8_vld  <= r_dv_vld[NUM_W-1];
            r_p9_vld  <= r_p8_vld;
            r_out_vld <= r_p9_vld;
        end
    end

    assign o_strobe = r_out_vld;
    assign o_rsp    = r_out;

    a_req_to_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##LAT o_strobe)
        else $error("request did not produce a result after the pipeline latency");

    a_zero_dist_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_p9_vld && r_p9_dz |=> o_strobe && o_rsp.overflow)
        else $error("zero cubed distance did not raise overflow");

    a_result_has_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_p7_vld |-> ##(NUM_W + 3) o_strobe)
        else $error("item lost between divider entry and result");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_strobe)
        else $error("result strobe after reset");

endmodule
`default_nettype wire
